[hw/rtl/ccc_pkg.sv]
// ----------------------------------------------------------------------------
// ccc_pkg
// shared types, codes and helpers for the counter continuity classifier
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  typedef enum logic [2:0] {
    CONT_FIRST  = 3'd0,
    CONT_CONT   = 3'd1,
    CONT_SAME   = 3'd2,
    CONT_WRAP   = 3'd3,
    CONT_RESET  = 3'd4,
    CONT_DISC   = 3'd5,
    CONT_AMBIG  = 3'd6,
    CONT_UNDET  = 3'd7
  } cont_t;

  typedef enum logic [2:0] {
    CFG_WIDTH_MODE = 3'd0,
    CFG_MAX_GAP    = 3'd1,
    CFG_RATE_EN    = 3'd2,
    CFG_MAX_RATE   = 3'd3,
    CFG_RESET_EN   = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    K_FIRST,
    K_RANGE,
    K_ANOM,
    K_GAP,
    K_SAME,
    K_FWD,
    K_BWRAP,
    K_RESET,
    K_BACK
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        amb_chk;
    logic [63:0] delta;
  } item_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
    sat_inc = (en && v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
  endfunction

endpackage

[hw/rtl/ccc_front.sv]
// ----------------------------------------------------------------------------
// ccc_front
// input register, previous reading state and first classification
// ----------------------------------------------------------------------------
module ccc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_take,
  input  logic [63:0]          raw_value,
  input  logic [63:0]          observed_ns,
  input  logic                 observed_valid,
  input  logic [63:0]          received_ns,
  input  logic                 width_mode,
  input  logic [62:0]          max_gap_ns,
  input  logic                 reset_detect_enable,
  output logic                 s1_valid,
  output ccc_pkg::item_t       s1_item,
  output logic [63:0]          s1_gap
);

  logic        v_r;
  logic [63:0] raw_r, obs_r, rcv_r;
  logic        obsv_r;
  logic        base_r;
  logic [63:0] prev_raw_r, prev_obs_r, prev_rcv_r;
  logic        prev_obsv_r;

  logic        wraps32;
  logic [63:0] earlier, later, gap, backwards;
  logic        anomaly;

  assign wraps32 = ~width_mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      base_r <= 1'b0;
      prev_obsv_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_take;
      if (v_r) begin
        base_r <= 1'b1;
        prev_obsv_r <= obsv_r;
        if (!(base_r && wraps32 && raw_r[63:32] != 32'd0)) begin
          prev_raw_r <= raw_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_take) begin
        raw_r <= raw_value;
        obs_r <= observed_ns;
        obsv_r <= observed_valid;
        rcv_r <= received_ns;
      end
      if (v_r) begin
        prev_obs_r <= obs_r;
        prev_rcv_r <= rcv_r;
      end
    end
  end

  always_comb begin
    if (obsv_r && prev_obsv_r) begin
      earlier = prev_obs_r;
      later = obs_r;
    end else begin
      earlier = prev_rcv_r;
      later = rcv_r;
    end
    anomaly = $signed(later) < $signed(earlier);
    gap = later - earlier;
    backwards = prev_raw_r - raw_r;
  end

  always_comb begin
    s1_item.amb_chk = wraps32;
    s1_item.delta = 64'd0;
    if (!base_r) begin
      s1_item.kind = ccc_pkg::K_FIRST;
    end else if (wraps32 && raw_r[63:32] != 32'd0) begin
      s1_item.kind = ccc_pkg::K_RANGE;
    end else if (anomaly) begin
      s1_item.kind = ccc_pkg::K_ANOM;
    end else if (max_gap_ns != 63'd0 && gap > {1'b0, max_gap_ns}) begin
      s1_item.kind = ccc_pkg::K_GAP;
    end else if (raw_r == prev_raw_r) begin
      s1_item.kind = ccc_pkg::K_SAME;
    end else if (raw_r > prev_raw_r) begin
      s1_item.kind = ccc_pkg::K_FWD;
      s1_item.delta = raw_r - prev_raw_r;
    end else if (wraps32 && backwards > 64'h8000_0000) begin
      s1_item.kind = ccc_pkg::K_BWRAP;
      s1_item.delta = 64'h1_0000_0000 - prev_raw_r + raw_r;
    end else if (reset_detect_enable) begin
      s1_item.kind = ccc_pkg::K_RESET;
    end else begin
      s1_item.kind = ccc_pkg::K_BACK;
    end
  end

  assign s1_valid = v_r;
  assign s1_gap = gap;

endmodule

[hw/rtl/ccc_rate.sv]
// ----------------------------------------------------------------------------
// ccc_rate
// two stage rate bound product and threshold, 32x32 partial products
// ----------------------------------------------------------------------------
module ccc_rate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 s1_valid,
  input  ccc_pkg::item_t       s1_item,
  input  logic [63:0]          s1_gap,
  input  logic [63:0]          max_rate,
  output logic                 s3_valid,
  output ccc_pkg::item_t       s3_item,
  output logic [127:0]         s3_prod,
  output logic [95:0]          s3_thr
);

  logic           v2_r, v3_r;
  ccc_pkg::item_t item2_r, item3_r;
  logic [63:0]    pp0_r, pp1_r, pp2_r, pp3_r;
  logic [61:0]    tp0_r, tp1_r;
  logic [127:0]   prod_r;
  logic [95:0]    thr_r;
  logic [63:0]    tval;

  assign tval = s1_item.delta + 64'h1_0000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v2_r <= s1_valid;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item2_r <= s1_item;
      pp0_r <= max_rate[31:0] * s1_gap[31:0];
      pp1_r <= max_rate[31:0] * s1_gap[63:32];
      pp2_r <= max_rate[63:32] * s1_gap[31:0];
      pp3_r <= max_rate[63:32] * s1_gap[63:32];
      tp0_r <= tval[31:0] * ccc_pkg::NS_PER_SEC;
      tp1_r <= tval[63:32] * ccc_pkg::NS_PER_SEC;
      item3_r <= item2_r;
      prod_r <= {pp3_r, pp0_r} + {32'd0, pp1_r, 32'd0} + {32'd0, pp2_r, 32'd0};
      thr_r <= {34'd0, tp0_r} + {2'd0, tp1_r, 32'd0};
    end
  end

  assign s3_valid = v3_r;
  assign s3_item = item3_r;
  assign s3_prod = prod_r;
  assign s3_thr = thr_r;

endmodule

[hw/rtl/counter_continuity_classifier.sv]
// ----------------------------------------------------------------------------
// counter_continuity_classifier
// classifies timestamped counter readings and keeps running tallies
//
//   channel  dir  handshake        payload
//   in_      in   tvalid/tready    tdata: reading and timestamps
//   out_     out  tvalid/tready    tdata: class, delta, tallies
//   cfg_     in   wr_en            index, data
//
// four register stages, one word per cycle while out_ is not held; the result
// reaches out_ after the input register, the 64x64 rate product in 32x32 parts
// and the tally and result register
// all stages advance together; a waiting result with out_tready low holds the
// whole pipeline
// rst_n clears stage valids, baseline and tallies; config returns to defaults
// ----------------------------------------------------------------------------
module counter_continuity_classifier (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // raw_value[63:0], observed_ns[127:64], observed_valid[128], received_ns[192:129]
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // continuity[2:0], delta_valid[3], delta_value[67:4], went_backward[68],
  // known_sum[132:69], known_count[164:133], unknown_count[196:165],
  // wrap_count[228:197], reset_count[260:229], gap_break_count[292:261],
  // ambiguous_count[324:293]
  output logic [327:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic        width_mode_r, rate_en_r, reset_en_r;
  logic [62:0] max_gap_r;
  logic [63:0] max_rate_r;

  logic           adv;
  logic           s1_valid, s3_valid;
  ccc_pkg::item_t s1_item, s3_item;
  logic [63:0]    s1_gap;
  logic [127:0]   s3_prod;
  logic [95:0]    s3_thr;

  logic        out_v_r;
  logic [2:0]  cont_r;
  logic        dvalid_r, back_r;
  logic [63:0] delta_r, sum_r;
  logic [31:0] kc_r, uc_r, wc_r, rc_r, gc_r, ac_r;

  logic        amb;
  ccc_pkg::cont_t cont_nxt;
  logic        dvalid_nxt, back_nxt;
  logic        inc_k, inc_u, inc_w, inc_r, inc_g, inc_a;

  assign adv = !out_v_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= 1'b1;
      max_gap_r <= 63'd0;
      rate_en_r <= 1'b0;
      max_rate_r <= 64'd0;
      reset_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ccc_pkg::CFG_WIDTH_MODE: width_mode_r <= cfg_data[0];
        ccc_pkg::CFG_MAX_GAP:    max_gap_r <= cfg_data[62:0];
        ccc_pkg::CFG_RATE_EN:    rate_en_r <= cfg_data[0];
        ccc_pkg::CFG_MAX_RATE:   max_rate_r <= cfg_data;
        ccc_pkg::CFG_RESET_EN:   reset_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ccc_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (adv),
    .in_take             (in_tvalid),
    .raw_value           (in_tdata[63:0]),
    .observed_ns         (in_tdata[127:64]),
    .observed_valid      (in_tdata[128]),
    .received_ns         (in_tdata[192:129]),
    .width_mode          (width_mode_r),
    .max_gap_ns          (max_gap_r),
    .reset_detect_enable (reset_en_r),
    .s1_valid            (s1_valid),
    .s1_item             (s1_item),
    .s1_gap              (s1_gap)
  );

  ccc_rate u_rate (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_gap   (s1_gap),
    .max_rate (max_rate_r),
    .s3_valid (s3_valid),
    .s3_item  (s3_item),
    .s3_prod  (s3_prod),
    .s3_thr   (s3_thr)
  );

  assign amb = rate_en_r && s3_item.amb_chk && s3_prod[127:64] == 64'd0 &&
               {32'd0, s3_prod[63:0]} >= s3_thr;

  always_comb begin
    cont_nxt = ccc_pkg::CONT_UNDET;
    dvalid_nxt = 1'b0;
    back_nxt = 1'b0;
    inc_k = 1'b0;
    inc_u = 1'b0;
    inc_w = 1'b0;
    inc_r = 1'b0;
    inc_g = 1'b0;
    inc_a = 1'b0;
    unique case (s3_item.kind)
      ccc_pkg::K_FIRST: cont_nxt = ccc_pkg::CONT_FIRST;
      ccc_pkg::K_RANGE, ccc_pkg::K_ANOM: inc_u = 1'b1;
      ccc_pkg::K_GAP: begin
        cont_nxt = ccc_pkg::CONT_DISC;
        inc_g = 1'b1;
        inc_u = 1'b1;
      end
      ccc_pkg::K_SAME: begin
        cont_nxt = ccc_pkg::CONT_SAME;
        dvalid_nxt = 1'b1;
        inc_k = 1'b1;
      end
      ccc_pkg::K_FWD, ccc_pkg::K_BWRAP: begin
        if (amb) begin
          cont_nxt = ccc_pkg::CONT_AMBIG;
          inc_a = 1'b1;
          inc_u = 1'b1;
        end else begin
          dvalid_nxt = 1'b1;
          inc_k = 1'b1;
          if (s3_item.kind == ccc_pkg::K_BWRAP) begin
            cont_nxt = ccc_pkg::CONT_WRAP;
            back_nxt = 1'b1;
            inc_w = 1'b1;
          end else begin
            cont_nxt = ccc_pkg::CONT_CONT;
          end
        end
      end
      ccc_pkg::K_RESET: begin
        cont_nxt = ccc_pkg::CONT_RESET;
        back_nxt = 1'b1;
        inc_r = 1'b1;
        inc_u = 1'b1;
      end
      ccc_pkg::K_BACK: begin
        back_nxt = 1'b1;
        inc_u = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sum_r <= 64'd0;
      kc_r <= 32'd0;
      uc_r <= 32'd0;
      wc_r <= 32'd0;
      rc_r <= 32'd0;
      gc_r <= 32'd0;
      ac_r <= 32'd0;
    end else if (adv) begin
      out_v_r <= s3_valid;
      if (s3_valid) begin
        if (dvalid_nxt && s3_item.kind != ccc_pkg::K_SAME) begin
          sum_r <= sum_r + s3_item.delta;
        end
        kc_r <= ccc_pkg::sat_inc(kc_r, inc_k);
        uc_r <= ccc_pkg::sat_inc(uc_r, inc_u);
        wc_r <= ccc_pkg::sat_inc(wc_r, inc_w);
        rc_r <= ccc_pkg::sat_inc(rc_r, inc_r);
        gc_r <= ccc_pkg::sat_inc(gc_r, inc_g);
        ac_r <= ccc_pkg::sat_inc(ac_r, inc_a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cont_r <= cont_nxt;
      dvalid_r <= dvalid_nxt;
      back_r <= back_nxt;
      delta_r <= (dvalid_nxt && s3_item.kind != ccc_pkg::K_SAME) ? s3_item.delta : 64'd0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {3'd0, ac_r, gc_r, rc_r, wc_r, uc_r, kc_r, sum_r,
                      back_r, delta_r, dvalid_r, cont_r};

endmodule
